// ----- sv/slcd_pkg.sv -----
// types, constants and helpers shared by the stn lcd scan controller
// no dependencies; used by the scan timing unit, the checker and the top level

package slcd_pkg;

  localparam int ROWS_DEF          = 160;
  localparam int BYTES_PER_ROW_DEF = 20;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_CP_HIGH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CP_LOW    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LP_HIGH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_WAIT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DISP_EN   = 3'd4;

  localparam logic [7:0]  CP_HIGH_RST  = 8'd1;
  localparam logic [7:0]  CP_LOW_RST   = 8'd1;
  localparam logic [7:0]  LP_HIGH_RST  = 8'd1;
  localparam logic [15:0] ROW_WAIT_RST = 16'd2000;

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  typedef enum logic [1:0] {
    PH_NIB_HIGH,
    PH_NIB_LOW,
    PH_LP_HIGH,
    PH_ROW_WAIT
  } phase_t;

  typedef struct packed {
    logic [7:0]  cp_high_ticks;
    logic [7:0]  cp_low_ticks;
    logic [7:0]  lp_high_ticks;
    logic [15:0] row_wait_ticks;
    logic        display_enable;
  } scan_cfg_t;

  // pin levels of the current scan state plus nibble fetch info
  typedef struct packed {
    logic       cp;
    logic       lp;
    logic       flm;
    logic       disp_on;
    logic [7:0] row;
    logic       nib_start;
    logic       nib_odd;
  } scan_view_t;

  function automatic logic [7:0] at_least_one(input logic [7:0] v);
    return (v == 8'd0) ? 8'd1 : v;
  endfunction

endpackage

// ----- sv/stn_lcd_scan_controller.sv -----
// stn lcd scan controller top level: stream ports, config registers, pipeline
// depends on slcd_pkg, slcd_scan and slcd_frame_store
//
// usage
//   s_axis carries one request per beat: tuser = op (tick or frame store write),
//   tdata = addr and data. every request, tick or write, yields one result on
//   m_axis with the lcd pin levels: a tick gives the levels during that tick,
//   a write the levels the current state drives.
//   cfg writes the timing registers and display enable; cfg_ready is always high.
//   write config only while no request is in flight.
//   path: the accepting edge loads the middle stage, and the output register takes
//   the result from it as soon as the output register is free.
//   throughput: one request per cycle while the output is not stalled; the scan
//   counters update in the cycle of acceptance and the frame store read (one port,
//   registered) lands with the middle stage, followed by the output register.
//   reset: control state returns to row 0, first nibble; then the frame store is
//   zeroed one byte a cycle, all ROWS*BYTES_PER_ROW bytes (3200 by default), while
//   s_axis_tready stays low. config writes are taken during that pass.
//   stall: with m_axis_tready low the output register holds, the middle stage
//   fills, and then s_axis_tready drops until the output drains.

module stn_lcd_scan_controller #(
  parameter int ROWS          = slcd_pkg::ROWS_DEF,
  parameter int BYTES_PER_ROW = slcd_pkg::BYTES_PER_ROW_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [23:0]                     s_axis_tdata,  // addr[11:0], data[19:12], pad
  input  logic                            s_axis_tuser,  // op
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [15:0]                     m_axis_tdata,  // cp, ld[4:1], lp, flm, disp_on, row[15:8]
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [slcd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [slcd_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int STORE_SIZE = ROWS * BYTES_PER_ROW;
  localparam int ADDR_W     = $clog2(STORE_SIZE);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_SIZE - 1);

  slcd_pkg::scan_cfg_t  cfg;
  slcd_pkg::scan_view_t view;
  slcd_pkg::scan_view_t a_view;
  slcd_pkg::scan_view_t b_view;

  logic              clearing;
  logic [ADDR_W-1:0] clr_addr;

  logic              accept, tick, wr, load;
  logic              in_op;
  logic [11:0]       in_addr;
  logic [7:0]        in_data;
  logic [ADDR_W-1:0] rd_addr;

  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_addr;
  logic [7:0]        mem_wdata, mem_rdata;

  logic              b_valid, b_free, c_free, b_move;
  logic [3:0]        data_pins;
  logic [3:0]        ld;

  assign in_op   = s_axis_tuser;
  assign in_addr = s_axis_tdata[11:0];
  assign in_data = s_axis_tdata[19:12];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cp_high_ticks  <= slcd_pkg::CP_HIGH_RST;
      cfg.cp_low_ticks   <= slcd_pkg::CP_LOW_RST;
      cfg.lp_high_ticks  <= slcd_pkg::LP_HIGH_RST;
      cfg.row_wait_ticks <= slcd_pkg::ROW_WAIT_RST;
      cfg.display_enable <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        slcd_pkg::REG_CP_HIGH:  cfg.cp_high_ticks  <= cfg_data[7:0];
        slcd_pkg::REG_CP_LOW:   cfg.cp_low_ticks   <= cfg_data[7:0];
        slcd_pkg::REG_LP_HIGH:  cfg.lp_high_ticks  <= cfg_data[7:0];
        slcd_pkg::REG_ROW_WAIT: cfg.row_wait_ticks <= cfg_data;
        slcd_pkg::REG_DISP_EN:  cfg.display_enable <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // frame store clearing pass after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + ADDR_W'(1);
      if (clr_addr == LAST_ADDR) begin
        clearing <= 1'b0;
      end
    end
  end

  assign c_free        = !m_axis_tvalid || m_axis_tready;
  assign b_free        = !b_valid || c_free;
  assign b_move        = b_valid && c_free;
  assign s_axis_tready = b_free && !clearing;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign tick = accept && (in_op == slcd_pkg::OP_TICK) && cfg.display_enable;
  assign wr   = accept && (in_op == slcd_pkg::OP_WRITE) &&
                ({20'd0, in_addr} < 32'(STORE_SIZE));
  assign load = tick && view.nib_start;

  always_comb begin
    mem_we    = clearing || wr;
    mem_re    = load;
    mem_wdata = clearing ? 8'd0 : in_data;
    if (clearing) begin
      mem_addr = clr_addr;
    end else if (wr) begin
      mem_addr = ADDR_W'(in_addr);
    end else begin
      mem_addr = rd_addr;
    end
  end

  slcd_scan #(
    .ROWS          (ROWS),
    .BYTES_PER_ROW (BYTES_PER_ROW),
    .ADDR_W        (ADDR_W)
  ) u_scan (
    .clk     (clk),
    .rst     (rst),
    .tick    (tick),
    .cfg     (cfg),
    .view    (view),
    .rd_addr (rd_addr)
  );

  slcd_frame_store #(
    .DEPTH  (STORE_SIZE),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // middle stage waits for the store read
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_free) begin
      b_valid <= accept;
    end
  end

  always_comb begin
    a_view           = view;
    a_view.nib_start = load;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_view <= a_view;
    end
  end

  assign ld = b_view.nib_start ? (b_view.nib_odd ? mem_rdata[3:0] : mem_rdata[7:4])
                               : data_pins;

  always_ff @(posedge clk) begin
    if (rst) begin
      data_pins <= 4'd0;
    end else if (b_move) begin
      data_pins <= ld;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (c_free) begin
      m_axis_tvalid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_move) begin
      m_axis_tdata <= {b_view.row, b_view.disp_on, b_view.flm, b_view.lp, ld, b_view.cp};
    end
  end

endmodule

// ----- sv/slcd_frame_store.sv -----
// single-port byte store for the frame buffer, registered read
// depends on nothing; instantiated by stn_lcd_scan_controller

module slcd_frame_store #(
  parameter int DEPTH  = 3200,
  parameter int ADDR_W = 12
) (
  input  logic              clk,
  input  logic              we,
  input  logic              re,
  input  logic [ADDR_W-1:0] addr,
  input  logic [7:0]        wdata,
  output logic [7:0]        rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ----- sv/slcd_scan.sv -----
// scan timing unit: phase, tick, nibble and row counters plus the flm level
// depends on slcd_pkg; instantiated by stn_lcd_scan_controller

module slcd_scan #(
  parameter int ROWS          = slcd_pkg::ROWS_DEF,
  parameter int BYTES_PER_ROW = slcd_pkg::BYTES_PER_ROW_DEF,
  parameter int ADDR_W        = $clog2(ROWS * BYTES_PER_ROW)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  tick,
  input  slcd_pkg::scan_cfg_t   cfg,
  output slcd_pkg::scan_view_t  view,
  output logic [ADDR_W-1:0]     rd_addr
);

  localparam int ROW_W = $clog2(ROWS);
  localparam int NIB_W = $clog2(2 * BYTES_PER_ROW + 1);
  localparam logic [ROW_W-1:0]  LAST_ROW = ROW_W'(ROWS - 1);
  localparam logic [NIB_W-1:0]  NIBS     = NIB_W'(2 * BYTES_PER_ROW);
  localparam logic [ADDR_W-1:0] BPR_A    = ADDR_W'(BYTES_PER_ROW);

  slcd_pkg::phase_t  phase, phase_next;
  logic [ROW_W-1:0]  row_count, row_count_next;
  logic [NIB_W-1:0]  nibble_count, nibble_count_next;
  logic [15:0]       tick_count, tick_count_next;
  logic              flm_level, flm_level_next;

  logic [16:0]       tick_inc;
  logic [NIB_W-1:0]  nib_inc;
  logic [ROW_W-1:0]  row_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= slcd_pkg::PH_NIB_HIGH;
      row_count    <= '0;
      nibble_count <= '0;
      tick_count   <= '0;
      flm_level    <= 1'b0;
    end else begin
      phase        <= phase_next;
      row_count    <= row_count_next;
      nibble_count <= nibble_count_next;
      tick_count   <= tick_count_next;
      flm_level    <= flm_level_next;
    end
  end

  always_comb begin
    tick_inc          = {1'b0, tick_count} + 17'd1;
    nib_inc           = nibble_count + NIB_W'(1);
    row_inc           = (row_count == LAST_ROW) ? '0 : row_count + ROW_W'(1);
    phase_next        = phase;
    row_count_next    = row_count;
    nibble_count_next = nibble_count;
    tick_count_next   = tick_count;
    flm_level_next    = flm_level;
    if (tick) begin
      tick_count_next = tick_inc[15:0];
      case (phase)
        slcd_pkg::PH_NIB_HIGH: begin
          if (tick_inc >= {9'd0, slcd_pkg::at_least_one(cfg.cp_high_ticks)}) begin
            phase_next      = slcd_pkg::PH_NIB_LOW;
            tick_count_next = '0;
          end
        end
        slcd_pkg::PH_NIB_LOW: begin
          if (tick_inc >= {9'd0, slcd_pkg::at_least_one(cfg.cp_low_ticks)}) begin
            tick_count_next   = '0;
            nibble_count_next = nib_inc;
            phase_next        = (nib_inc >= NIBS) ? slcd_pkg::PH_LP_HIGH
                                                  : slcd_pkg::PH_NIB_HIGH;
          end
        end
        slcd_pkg::PH_LP_HIGH: begin
          if (tick_inc >= {9'd0, slcd_pkg::at_least_one(cfg.lp_high_ticks)}) begin
            if (row_count == '0) begin
              flm_level_next = 1'b1;
            end else if (row_count == ROW_W'(1)) begin
              flm_level_next = 1'b0;
            end
            tick_count_next = '0;
            if (cfg.row_wait_ticks == 16'd0) begin
              row_count_next    = row_inc;
              nibble_count_next = '0;
              phase_next        = slcd_pkg::PH_NIB_HIGH;
            end else begin
              phase_next = slcd_pkg::PH_ROW_WAIT;
            end
          end
        end
        default: begin
          if (tick_inc >= {1'b0, cfg.row_wait_ticks}) begin
            row_count_next    = row_inc;
            nibble_count_next = '0;
            phase_next        = slcd_pkg::PH_NIB_HIGH;
            tick_count_next   = '0;
          end
        end
      endcase
    end
  end

  always_comb begin
    view.cp        = cfg.display_enable && (phase == slcd_pkg::PH_NIB_HIGH);
    view.lp        = cfg.display_enable && (phase == slcd_pkg::PH_LP_HIGH);
    view.flm       = flm_level;
    view.disp_on   = cfg.display_enable;
    view.row       = 8'(row_count);
    view.nib_start = (phase == slcd_pkg::PH_NIB_HIGH) && (tick_count == 16'd0);
    view.nib_odd   = nibble_count[0];
    rd_addr        = ADDR_W'(row_count) * BPR_A + ADDR_W'(nibble_count >> 1);
  end

endmodule

// ----- sv/slcd_checker.sv -----
// port-level checks for the stn lcd scan controller, bound to the top level
// depends on slcd_pkg and stn_lcd_scan_controller

module slcd_checker #(
  parameter int ROWS = slcd_pkg::ROWS_DEF
) (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  // held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result payload changed while stalled");

  // pixel clock and latch pulse are never high together
  a_cp_lp: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[5]))
    else $error("cp and lp high together");

  // no shift or latch activity while the display is off
  a_disp_off: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[7] |-> !m_axis_tdata[0] && !m_axis_tdata[5])
    else $error("cp or lp active with display off");

  a_row_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (ROWS > 256) || (m_axis_tdata[15:8] < ROWS))
    else $error("row out of range");

  // store clearing blocks requests right after reset
  a_clear_block: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !s_axis_tready)
    else $error("request taken during frame store clearing");

endmodule

bind stn_lcd_scan_controller slcd_checker #(
  .ROWS (ROWS)
) u_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
